@@ rtl/core/spm_pkg.sv @@
// Shared constants and control types for the sparse polynomial merge-add core.
`default_nettype none
package spm_pkg;

    localparam int MAX_TERMS_DEF = 16;
    localparam int POW_W = 31;
    localparam int COEF_W = 32;
    localparam int KIND_W = 2;

    localparam logic [KIND_W-1:0] KIND_LOAD_A = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD_B = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MERGE = 2'd2;

    typedef struct packed {
        logic load_a;
        logic load_b;
        logic emit_empty;
        logic begin_merge;
        logic step;
    } cmd_t;

    typedef struct packed {
        logic stores_empty;
        logic step_last;
    } status_t;

endpackage
`default_nettype wire

@@ rtl/core/spm_ctrl.sv @@
// Controller state machine that sequences loads and the merge walk.
`default_nettype none
module spm_ctrl (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [spm_pkg::KIND_W-1:0] kind,
    input  wire spm_pkg::status_t           status,
    output spm_pkg::cmd_t                   cmd,
    output logic                            busy
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_MERGE = 1'b1;

    logic state_reg;
    logic state_next;

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (kind)
                        spm_pkg::KIND_LOAD_A: cmd.load_a = 1'b1;
                        spm_pkg::KIND_LOAD_B: cmd.load_b = 1'b1;
                        spm_pkg::KIND_MERGE:
                        begin
                            if (status.stores_empty)
                            begin
                                cmd.emit_empty = 1'b1;
                            end
                            else
                            begin
                                cmd.begin_merge = 1'b1;
                                state_next = ST_MERGE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_MERGE:
            begin
                cmd.step = 1'b1;
                if (status.step_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg == ST_MERGE);

endmodule
`default_nettype wire

@@ rtl/core/spm_dpath.sv @@
// Datapath: term stores, fill counts, merge heads, comparator, adder and result registers.
`default_nettype none
module spm_dpath #(
    parameter int MAX_TERMS = spm_pkg::MAX_TERMS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire spm_pkg::cmd_t                     cmd,
    input  wire logic [spm_pkg::POW_W-1:0]         term_power,
    input  wire logic signed [spm_pkg::COEF_W-1:0] term_coef,
    output spm_pkg::status_t                       status,
    output logic                                   strobe,
    output logic [spm_pkg::POW_W-1:0]              sum_power,
    output logic signed [spm_pkg::COEF_W-1:0]      sum_coef,
    output logic                                   valid_res,
    output logic                                   last,
    output logic                                   dropped
);

    localparam int CNT_W = $clog2(MAX_TERMS + 1);
    localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TERMS);

    logic [spm_pkg::POW_W-1:0]  a_pow_reg [MAX_TERMS];
    logic [spm_pkg::COEF_W-1:0] a_coef_reg [MAX_TERMS];
    logic [spm_pkg::POW_W-1:0]  b_pow_reg [MAX_TERMS];
    logic [spm_pkg::COEF_W-1:0] b_coef_reg [MAX_TERMS];

    logic [CNT_W-1:0] a_cnt_reg;
    logic [CNT_W-1:0] b_cnt_reg;
    logic [CNT_W-1:0] ia_reg;
    logic [CNT_W-1:0] ib_reg;
    logic [CNT_W-1:0] ia_next;
    logic [CNT_W-1:0] ib_next;
    logic             ovf_reg;
    logic             strobe_reg;

    logic [spm_pkg::POW_W-1:0]         sum_power_reg;
    logic signed [spm_pkg::COEF_W-1:0] sum_coef_reg;
    logic                              valid_res_reg;
    logic                              last_reg;
    logic                              dropped_reg;

    logic [spm_pkg::POW_W-1:0]  a_head_pow;
    logic [spm_pkg::COEF_W-1:0] a_head_coef;
    logic [spm_pkg::POW_W-1:0]  b_head_pow;
    logic [spm_pkg::COEF_W-1:0] b_head_coef;
    logic                       a_has;
    logic                       b_has;
    logic                       take_a;
    logic                       take_b;
    logic [spm_pkg::POW_W-1:0]  step_pow;
    logic [spm_pkg::COEF_W-1:0] step_coef;

    assign a_head_pow = a_pow_reg[ia_reg[IDX_W-1:0]];
    assign a_head_coef = a_coef_reg[ia_reg[IDX_W-1:0]];
    assign b_head_pow = b_pow_reg[ib_reg[IDX_W-1:0]];
    assign b_head_coef = b_coef_reg[ib_reg[IDX_W-1:0]];

    assign a_has = (ia_reg < a_cnt_reg);
    assign b_has = (ib_reg < b_cnt_reg);

    // Only the current heads are compared; an unsorted list is walked as given.
    always_comb
    begin
        take_a = a_has && (!b_has || (a_head_pow < b_head_pow));
        take_b = !take_a && (!a_has || (b_head_pow < a_head_pow));
        ia_next = ia_reg;
        ib_next = ib_reg;
        if (take_a)
        begin
            step_pow = a_head_pow;
            step_coef = a_head_coef;
            ia_next = ia_reg + CNT_W'(1);
        end
        else if (take_b)
        begin
            step_pow = b_head_pow;
            step_coef = b_head_coef;
            ib_next = ib_reg + CNT_W'(1);
        end
        else
        begin
            step_pow = b_head_pow;
            step_coef = a_head_coef + b_head_coef;
            ia_next = ia_reg + CNT_W'(1);
            ib_next = ib_reg + CNT_W'(1);
        end
    end

    assign status.stores_empty = (a_cnt_reg == '0) && (b_cnt_reg == '0);
    assign status.step_last = (ia_next >= a_cnt_reg) && (ib_next >= b_cnt_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load_a && (a_cnt_reg < CNT_MAX))
        begin
            a_pow_reg[a_cnt_reg[IDX_W-1:0]] <= term_power;
            a_coef_reg[a_cnt_reg[IDX_W-1:0]] <= term_coef;
        end
        if (cmd.load_b && (b_cnt_reg < CNT_MAX))
        begin
            b_pow_reg[b_cnt_reg[IDX_W-1:0]] <= term_power;
            b_coef_reg[b_cnt_reg[IDX_W-1:0]] <= term_coef;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_empty)
        begin
            sum_power_reg <= '0;
            sum_coef_reg <= '0;
            valid_res_reg <= 1'b0;
            last_reg <= 1'b1;
            dropped_reg <= ovf_reg;
        end
        else if (cmd.step)
        begin
            sum_power_reg <= step_pow;
            sum_coef_reg <= step_coef;
            valid_res_reg <= 1'b1;
            last_reg <= status.step_last;
            dropped_reg <= ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_cnt_reg <= '0;
            b_cnt_reg <= '0;
            ia_reg <= '0;
            ib_reg <= '0;
            ovf_reg <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= cmd.emit_empty || cmd.step;
            if (cmd.load_a)
            begin
                if (a_cnt_reg < CNT_MAX)
                begin
                    a_cnt_reg <= a_cnt_reg + CNT_W'(1);
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end
            if (cmd.load_b)
            begin
                if (b_cnt_reg < CNT_MAX)
                begin
                    b_cnt_reg <= b_cnt_reg + CNT_W'(1);
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end
            if (cmd.begin_merge)
            begin
                ia_reg <= '0;
                ib_reg <= '0;
            end
            if (cmd.emit_empty)
            begin
                ovf_reg <= 1'b0;
            end
            if (cmd.step)
            begin
                ia_reg <= ia_next;
                ib_reg <= ib_next;
                if (status.step_last)
                begin
                    a_cnt_reg <= '0;
                    b_cnt_reg <= '0;
                    ovf_reg <= 1'b0;
                end
            end
        end
    end

    assign strobe = strobe_reg;
    assign sum_power = sum_power_reg;
    assign sum_coef = sum_coef_reg;
    assign valid_res = valid_res_reg;
    assign last = last_reg;
    assign dropped = dropped_reg;

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && !valid_res_reg) |-> last_reg)
        else $error("empty result not marked last");

    a_step_has_term: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (a_has || b_has))
        else $error("merge step with both stores exhausted");

    a_cleared_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && last_reg) |-> ((a_cnt_reg == '0) && (b_cnt_reg == '0) && !ovf_reg))
        else $error("stores not emptied after final result");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (a_cnt_reg <= CNT_MAX) && (b_cnt_reg <= CNT_MAX))
        else $error("fill count beyond store depth");

endmodule
`default_nettype wire

@@ rtl/core/sparse_poly_term_merge_add_core.sv @@
// Top level of the sparse polynomial merge-add core: controller plus datapath.
// A load item (kind 0 or 1) keeps busy low and gives no result.
// A merge item gives one result per cycle, each step's result registered; busy is high while
// the merge walk runs, giving a_count + b_count - matched powers results, at most 2*MAX_TERMS.
// A merge of two empty stores gives one result the next cycle, with busy staying low.
// Results cannot be held off. Reset clears counts, drop flag and state; store contents are not reset.
`default_nettype none
module sparse_poly_term_merge_add_core #(
    parameter int MAX_TERMS = spm_pkg::MAX_TERMS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [spm_pkg::KIND_W-1:0]        kind,
    input  wire logic [spm_pkg::POW_W-1:0]         term_power,
    input  wire logic signed [spm_pkg::COEF_W-1:0] term_coef,
    output logic                                   strobe,
    output logic [spm_pkg::POW_W-1:0]              sum_power,
    output logic signed [spm_pkg::COEF_W-1:0]      sum_coef,
    output logic                                   valid_res,
    output logic                                   last,
    output logic                                   dropped
);

    spm_pkg::cmd_t    cmd;
    spm_pkg::status_t status;

    spm_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .kind   (kind),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    spm_dpath #(
        .MAX_TERMS (MAX_TERMS)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .term_power (term_power),
        .term_coef  (term_coef),
        .status     (status),
        .strobe     (strobe),
        .sum_power  (sum_power),
        .sum_coef   (sum_coef),
        .valid_res  (valid_res),
        .last       (last),
        .dropped    (dropped)
    );

endmodule
`default_nettype wire

@@ tb/sparse_poly_term_merge_add_core_tb.sv @@
// Self-checking testbench for the sparse polynomial merge-add core.
`timescale 1ns / 1ps

module sparse_poly_term_merge_add_core_tb;

    localparam int DEPTH = spm_pkg::MAX_TERMS_DEF;
    localparam int KIND_W = spm_pkg::KIND_W;
    localparam int POW_W = spm_pkg::POW_W;
    localparam int COEF_W = spm_pkg::COEF_W;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam logic [POW_W-1:0] POW_TOP = 31'h7FFFFFFF;
    localparam logic signed [COEF_W-1:0] COEF_MAX = 32'sh7FFFFFFF;
    localparam logic signed [COEF_W-1:0] COEF_MIN = 32'sh80000000;
    localparam int IDLE_PCT = 37;
    localparam int QUIET_LIMIT = 1000;
    localparam int RANDOM_ITEMS = 300;
    localparam int REPORT_MAX = 10;

    typedef struct {
        logic [POW_W-1:0]         power;
        logic signed [COEF_W-1:0] coef;
        logic                     valid;
        logic                     last;
        logic                     dropped;
    } sum_term_t;

    class term_sum_board;
        logic [POW_W-1:0]         a_pow[DEPTH];
        logic signed [COEF_W-1:0] a_coef[DEPTH];
        logic [POW_W-1:0]         b_pow[DEPTH];
        logic signed [COEF_W-1:0] b_coef[DEPTH];
        int                       a_len;
        int                       b_len;
        bit                       drop_seen;
        sum_term_t                pending_terms[$];
        int                       errors;
        int                       terms_checked;
        int                       merges;
        int                       drop_merges;

        function new();
            a_len = 0;
            b_len = 0;
            drop_seen = 1'b0;
            errors = 0;
            terms_checked = 0;
            merges = 0;
            drop_merges = 0;
        endfunction

        // Updates the stores for one accepted item and queues the terms a merge will emit.
        function void note_item(logic [KIND_W-1:0] item_kind, logic [POW_W-1:0] item_power,
                                logic signed [COEF_W-1:0] item_coef);
            sum_term_t t;
            int        ia;
            int        ib;
            ia = 0;
            ib = 0;
            if (item_kind == spm_pkg::KIND_LOAD_A) begin
                if (a_len < DEPTH) begin
                    a_pow[a_len] = item_power;
                    a_coef[a_len] = item_coef;
                    a_len++;
                end else begin
                    drop_seen = 1'b1;
                end
            end else if (item_kind == spm_pkg::KIND_LOAD_B) begin
                if (b_len < DEPTH) begin
                    b_pow[b_len] = item_power;
                    b_coef[b_len] = item_coef;
                    b_len++;
                end else begin
                    drop_seen = 1'b1;
                end
            end else if (item_kind == spm_pkg::KIND_MERGE) begin
                merges++;
                if (drop_seen)
                    drop_merges++;
                if (a_len == 0 && b_len == 0) begin
                    t.power = '0;
                    t.coef = '0;
                    t.valid = 1'b0;
                    t.last = 1'b1;
                    t.dropped = drop_seen;
                    pending_terms.push_back(t);
                end
                // Only the current heads are compared, so unsorted lists merge as they stand.
                while (ia < a_len || ib < b_len) begin
                    if (ia < a_len && (ib >= b_len || a_pow[ia] < b_pow[ib])) begin
                        t.power = a_pow[ia];
                        t.coef = a_coef[ia];
                        ia++;
                    end else if (ia >= a_len || b_pow[ib] < a_pow[ia]) begin
                        t.power = b_pow[ib];
                        t.coef = b_coef[ib];
                        ib++;
                    end else begin
                        t.power = b_pow[ib];
                        t.coef = a_coef[ia] + b_coef[ib];
                        ia++;
                        ib++;
                    end
                    t.valid = 1'b1;
                    t.last = (ia >= a_len && ib >= b_len);
                    t.dropped = drop_seen;
                    pending_terms.push_back(t);
                end
                a_len = 0;
                b_len = 0;
                drop_seen = 1'b0;
            end
        endfunction

        function void check_term(sum_term_t got);
            sum_term_t want;
            if (pending_terms.size() == 0) begin
                if (errors < REPORT_MAX)
                    $display("error: unexpected term power=%0d coef=%0d valid=%0b last=%0b",
                             got.power, got.coef, got.valid, got.last);
                errors++;
                return;
            end
            want = pending_terms.pop_front();
            terms_checked++;
            if (got.power !== want.power || got.coef !== want.coef ||
                got.valid !== want.valid || got.last !== want.last ||
                got.dropped !== want.dropped) begin
                if (errors < REPORT_MAX) begin
                    $display("error: term %0d expected power=%0d coef=%0d valid=%0b last=%0b dropped=%0b",
                             terms_checked, want.power, want.coef, want.valid, want.last,
                             want.dropped);
                    $display("       got power=%0d coef=%0d valid=%0b last=%0b dropped=%0b",
                             got.power, got.coef, got.valid, got.last, got.dropped);
                end
                errors++;
            end
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [KIND_W-1:0]        kind;
    logic [POW_W-1:0]         term_power;
    logic signed [COEF_W-1:0] term_coef;
    logic                     strobe;
    logic [POW_W-1:0]         sum_power;
    logic signed [COEF_W-1:0] sum_coef;
    logic                     valid_res;
    logic                     last;
    logic                     dropped;

    term_sum_board board;
    sum_term_t     seen_term;
    bit            idle_on;
    int            items_sent;
    int            quiet_cycles;

    sparse_poly_term_merge_add_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .kind(kind),
        .term_power(term_power),
        .term_coef(term_coef),
        .strobe(strobe),
        .sum_power(sum_power),
        .sum_coef(sum_coef),
        .valid_res(valid_res),
        .last(last),
        .dropped(dropped)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && strobe) begin
            seen_term.power = sum_power;
            seen_term.coef = sum_coef;
            seen_term.valid = valid_res;
            seen_term.last = last;
            seen_term.dropped = dropped;
            board.check_term(seen_term);
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || strobe)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no item or result for %0d cycles", QUIET_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic signed [COEF_W-1:0] rand_coef();
        case ($urandom_range(9))
            0: return COEF_MAX;
            1: return COEF_MIN;
            2, 3: return $urandom_range(6) - 3;
            default: return $urandom();
        endcase
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 8)
            return DEPTH + $urandom_range(3, 1);
        if (r < 16)
            return DEPTH;
        if (r < 24)
            return 0;
        return $urandom_range(6, 1);
    endfunction

    // Drives one item, holding start until the block takes it, after an optional random gap.
    task automatic send_item(logic [KIND_W-1:0] item_kind, logic [POW_W-1:0] item_power,
                             logic signed [COEF_W-1:0] item_coef);
        int gap;
        gap = 0;
        // Each cycle idles with the same chance, so about that share of cycles is idle.
        while (idle_on && $urandom_range(99) < IDLE_PCT)
            gap++;
        if (gap > 0) begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start <= 1'b1;
        kind <= item_kind;
        term_power <= item_power;
        term_coef <= item_coef;
        do
            @(posedge clk);
        while (busy);
        board.note_item(item_kind, item_power, item_coef);
        if (item_kind != KIND_UNUSED)
            items_sent++;
    endtask

    initial
    begin
        logic [POW_W-1:0] pa[$];
        logic [POW_W-1:0] pb[$];
        int               na;
        int               nb;
        int               ia;
        int               ib;
        int               random_from;
        bit               wide;

        board = new();
        rst_n = 1'b0;
        start = 1'b0;
        kind = spm_pkg::KIND_LOAD_A;
        term_power = '0;
        term_coef = '0;
        idle_on = 1'b1;
        items_sent = 0;
        quiet_cycles = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Merge with both stores empty.
        send_item(spm_pkg::KIND_MERGE, '0, '0);
        // Equal powers at both ends of the range, with coefficient wrap and a zero sum;
        // an unused kind in the middle must leave the stores alone.
        send_item(spm_pkg::KIND_LOAD_A, '0, COEF_MAX);
        send_item(spm_pkg::KIND_LOAD_B, '0, 32'sd1);
        send_item(spm_pkg::KIND_LOAD_A, 31'd9, 32'sd100);
        send_item(spm_pkg::KIND_LOAD_B, 31'd3, -32'sd5);
        send_item(KIND_UNUSED, POW_TOP, -32'sd1);
        send_item(spm_pkg::KIND_LOAD_B, 31'd9, -32'sd100);
        send_item(spm_pkg::KIND_LOAD_A, POW_TOP, COEF_MIN);
        send_item(spm_pkg::KIND_LOAD_B, POW_TOP, COEF_MAX);
        send_item(spm_pkg::KIND_MERGE, POW_TOP, -32'sd1);
        // Only store A holds a term.
        send_item(spm_pkg::KIND_LOAD_A, 31'd4, -32'sd3);
        send_item(spm_pkg::KIND_MERGE, '0, '0);
        // Store B loaded out of order.
        send_item(spm_pkg::KIND_LOAD_B, 31'd10, 32'sd1);
        send_item(spm_pkg::KIND_LOAD_B, 31'd2, 32'sd2);
        send_item(spm_pkg::KIND_LOAD_A, 31'd5, 32'sd3);
        send_item(spm_pkg::KIND_MERGE, '0, '0);
        // Store A overflows by one term while B stays empty.
        for (int i = 0; i <= DEPTH; i++)
            send_item(spm_pkg::KIND_LOAD_A, 31'(i * 3), rand_coef());
        send_item(spm_pkg::KIND_MERGE, '0, '0);

        random_from = items_sent;
        while (items_sent - random_from < RANDOM_ITEMS) begin
            idle_on = !(items_sent - random_from >= 100 && items_sent - random_from < 180);
            if ($urandom_range(99) < 80) begin
                // Two lists in ascending order (list A sometimes shuffled), loaded interleaved, then merged.
                na = pick_len();
                nb = pick_len();
                wide = ($urandom_range(3) == 0);
                pa.delete();
                pb.delete();
                for (int i = 0; i < na; i++)
                    pa.push_back(wide ? POW_W'($urandom()) : POW_W'($urandom_range(40)));
                for (int i = 0; i < nb; i++)
                    pb.push_back(wide ? POW_W'($urandom()) : POW_W'($urandom_range(40)));
                pa.sort();
                pb.sort();
                if ($urandom_range(9) == 0)
                    pa.shuffle();
                ia = 0;
                ib = 0;
                while (ia < na || ib < nb) begin
                    if ($urandom_range(24) == 0)
                        send_item(KIND_UNUSED, POW_W'($urandom()), $urandom());
                    if (ib >= nb || (ia < na && $urandom_range(1) == 1)) begin
                        send_item(spm_pkg::KIND_LOAD_A, pa[ia], rand_coef());
                        ia++;
                    end else begin
                        send_item(spm_pkg::KIND_LOAD_B, pb[ib], rand_coef());
                        ib++;
                    end
                end
                send_item(spm_pkg::KIND_MERGE, POW_W'($urandom()), $urandom());
            end else begin
                repeat ($urandom_range(6, 1))
                    send_item(KIND_W'($urandom_range(3)), POW_W'($urandom()), $urandom());
            end
        end

        @(negedge clk);
        start <= 1'b0;
        while (board.pending_terms.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("Sent %0d load and merge items; %0d merges, %0d of them after dropped loads.",
                 items_sent, board.merges, board.drop_merges);
        $display("Checked %0d result terms, %0d errors.", board.terms_checked, board.errors);
        if (board.errors == 0 && board.pending_terms.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
